FILE: hdl/dic_pkg.sv
// ----------------------------------------------------------------------------
// dic_pkg - shared types and constants for the inversion counter
// Field widths of the request and response words, the sequencer states and
// the control word passed to the shared compare unit.
// ----------------------------------------------------------------------------
package dic_pkg;

	localparam int FUNC_W = 1;
	localparam int POS_W  = 10;
	localparam int VAL_W  = 16;
	localparam int INV_W  = 19;

	// operation codes carried in the func field
	localparam logic [FUNC_W-1:0] FUNC_APPEND = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_UPDATE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SCAN,
		ST_WRITE,
		ST_RESULT
	} dic_state_t;

	// control for one compare step
	typedef struct packed {
		logic upd;     // update word, not an append
		logic below;   // scanned entry lies below the updated position
		logic after;   // scanned entry lies above the updated position
	} dic_cmp_ctl_t;

endpackage

FILE: hdl/dic_if.sv
// ----------------------------------------------------------------------------
// dic_if - request and response channels of the inversion counter
// Valid/ready channels; a word moves on an edge with both high.
// ----------------------------------------------------------------------------
interface dic_in_if;
	import dic_pkg::*;

	logic             valid;
	logic             ready;
	logic [FUNC_W-1:0] func;
	logic [POS_W-1:0]  pos;
	logic [VAL_W-1:0]  val;

	modport source (output valid, func, pos, val, input ready);
	modport sink   (input valid, func, pos, val, output ready);
endinterface

interface dic_out_if;
	import dic_pkg::*;

	logic             valid;
	logic             ready;
	logic [INV_W-1:0] inversions;
	logic             error;

	modport source (output valid, inversions, error, input ready);
	modport sink   (input valid, inversions, error, output ready);
endinterface

FILE: hdl/dic_cmp_unit.sv
// ----------------------------------------------------------------------------
// dic_cmp_unit - shared compare and count step
// Compares one stored entry against the old and new values and returns the
// corrected inversion count.
// ----------------------------------------------------------------------------
module dic_cmp_unit #(
	parameter int VALUE_BITS = 16,
	parameter int CNT_W      = 20
) (
	input  dic_pkg::dic_cmp_ctl_t  ctl,
	input  logic [VALUE_BITS-1:0]  entry,
	input  logic [VALUE_BITS-1:0]  old_val,
	input  logic [VALUE_BITS-1:0]  new_val,
	input  logic [CNT_W-1:0]       cnt,
	output logic [CNT_W-1:0]       cnt_nxt
);
	import dic_pkg::*;

	logic inc;
	logic dec;

	always_comb begin
		inc = 1'b0;
		dec = 1'b0;
		if (!ctl.upd) begin
			inc = entry > new_val;
		end else if (ctl.below) begin
			dec = entry > old_val;
			inc = entry > new_val;
		end else if (ctl.after) begin
			dec = entry < old_val;
			inc = entry < new_val;
		end
	end

	assign cnt_nxt = cnt + CNT_W'(inc) - CNT_W'(dec);

endmodule

FILE: hdl/dynamic_inversion_counter_unit.sv
// ----------------------------------------------------------------------------
// dynamic_inversion_counter_unit - running inversion count over a value store
// Sequence: an append reads every stored entry once through the store's read
//   port, then drains the last read, writes and answers; an update first
//   fetches the old value at its position. A rejected word is answered in
//   the cycle after acceptance.
// Throughput: one word at a time; the next request is taken after the
//   response is handed over.
// Reset: arst_n clears the length, count and sequencer; store contents are
//   left as they are and only loaded entries are ever read.
// ----------------------------------------------------------------------------
module dynamic_inversion_counter_unit #(
	parameter int MAX_ITEMS  = 1024,
	parameter int VALUE_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	dic_in_if.sink           req,
	dic_out_if.source        rsp
);
	import dic_pkg::*;

	localparam int    ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int    LEN_W     = $clog2(MAX_ITEMS + 1);
	localparam longint PAIRS    = (longint'(MAX_ITEMS) * (MAX_ITEMS - 1)) / 2;
	localparam int    CNT_BITS  = $clog2(PAIRS + 1);
	localparam int    CNT_W     = (CNT_BITS > INV_W) ? CNT_BITS : INV_W;

	// sequencer
	dic_state_t state_q, state_nxt;

	// word held for the duration of the scan
	logic [FUNC_W-1:0]     func_q;
	logic [ADDR_W-1:0]     pos_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [VALUE_BITS-1:0] old_q;
	logic                  old_pend_q;
	logic                  err_q;

	// architectural state
	logic [LEN_W-1:0]      len_q;
	logic [CNT_W-1:0]      cnt_q;

	// scan pointer and the read in flight
	logic [LEN_W-1:0]      idx_q;
	logic                  rd_vld_s1;
	logic [ADDR_W-1:0]     idx_s1;

	// value store, one read port and one write port
	logic [VALUE_BITS-1:0] mem_q [MAX_ITEMS];
	logic [VALUE_BITS-1:0] rd_data_q;
	logic [ADDR_W-1:0]     rd_addr;
	logic [ADDR_W-1:0]     wr_addr;
	logic                  mem_we;
	logic                  issue;

	logic                  acc;
	logic                  err_in;
	logic [31:0]           pos_w;
	logic [31:0]           len_w;
	logic [VAL_W+31:0]     val_w;
	logic                  scan_done;

	dic_cmp_ctl_t          cmp_ctl;
	logic [CNT_W-1:0]      cnt_nxt;

	// widen the request fields so the checks hold for any parameter set
	assign pos_w = 32'(req.pos);
	assign len_w = 32'(len_q);
	assign val_w = {32'd0, req.val};

	assign acc = req.valid && req.ready;

	// reject an append to a full store or an update beyond the loaded length
	assign err_in = (req.func == FUNC_UPDATE) ? (pos_w >= len_w)
	                                          : (len_q == LEN_W'(MAX_ITEMS));

	assign scan_done = (idx_q == len_q) && !rd_vld_s1;

	// ---- next state ----
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (err_in) begin
						state_nxt = ST_RESULT;
					end else if (req.func == FUNC_UPDATE) begin
						state_nxt = ST_FETCH;
					end else begin
						state_nxt = ST_SCAN;
					end
				end
			end
			ST_FETCH: state_nxt = ST_SCAN;
			ST_SCAN: begin
				if (scan_done) begin
					state_nxt = ST_WRITE;
				end
			end
			ST_WRITE: state_nxt = ST_RESULT;
			ST_RESULT: begin
				if (rsp.ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// ---- outputs of the sequencer ----
	always_comb begin
		req.ready = 1'b0;
		rsp.valid = 1'b0;
		issue     = 1'b0;
		mem_we    = 1'b0;
		rd_addr   = idx_q[ADDR_W-1:0];
		case (state_q)
			ST_IDLE:   req.ready = 1'b1;
			ST_FETCH:  rd_addr   = pos_q;
			ST_SCAN:   issue     = idx_q != len_q;
			ST_WRITE:  mem_we    = 1'b1;
			ST_RESULT: rsp.valid = 1'b1;
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	// an append lands at the current end, an update at its position
	assign wr_addr = (func_q == FUNC_UPDATE) ? pos_q : len_q[ADDR_W-1:0];

	// ---- store ----
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_addr] <= val_q;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	// ---- shared compare unit ----
	assign cmp_ctl.upd    = func_q == FUNC_UPDATE;
	assign cmp_ctl.below  = idx_s1 < pos_q;
	assign cmp_ctl.after  = idx_s1 > pos_q;

	dic_cmp_unit #(
		.VALUE_BITS (VALUE_BITS),
		.CNT_W      (CNT_W)
	) u_cmp (
		.ctl     (cmp_ctl),
		.entry   (rd_data_q),
		.old_val (old_q),
		.new_val (val_q),
		.cnt     (cnt_q),
		.cnt_nxt (cnt_nxt)
	);

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			len_q      <= '0;
			cnt_q      <= '0;
			idx_q      <= '0;
			rd_vld_s1  <= 1'b0;
			old_pend_q <= 1'b0;
			err_q      <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			rd_vld_s1  <= issue;
			// the old value arrives in the cycle after the fetch
			old_pend_q <= state_q == ST_FETCH;
			if (acc) begin
				err_q <= err_in;
				idx_q <= '0;
			end
			if (issue) begin
				idx_q <= idx_q + LEN_W'(1);
			end
			if (rd_vld_s1) begin
				cnt_q <= cnt_nxt;
			end
			if (mem_we && func_q == FUNC_APPEND) begin
				len_q <= len_q + LEN_W'(1);
			end
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (acc) begin
			func_q <= req.func;
			pos_q  <= pos_w[ADDR_W-1:0];
			val_q  <= val_w[VALUE_BITS-1:0];
		end
		if (old_pend_q) begin
			old_q <= rd_data_q;
		end
		idx_s1 <= idx_q[ADDR_W-1:0];
	end

	// hand over the low bits of the count
	assign rsp.inversions = cnt_q[INV_W-1:0];
	assign rsp.error      = err_q;

endmodule

FILE: hdl/dic_checker.sv
// ----------------------------------------------------------------------------
// dic_checker - port-level checks for the inversion counter
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module dic_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic [dic_pkg::INV_W-1:0] rsp_inversions,
	input logic                      rsp_error
);
	import dic_pkg::*;

	// a taken word closes the request side until its response is out
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request side still open after a word was taken");

	// never take a new word while a response is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rsp_valid && req_ready))
		else $error("request taken while a response waits");

	// a stalled response stays up
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("response dropped before it was taken");

	// a stalled response keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> ($stable(rsp_inversions) && $stable(rsp_error)))
		else $error("response payload changed while stalled");

endmodule

bind dynamic_inversion_counter_unit dic_checker u_dic_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_inversions (rsp.inversions),
	.rsp_error      (rsp.error)
);
